[hdl/lcs_pkg.sv]
// shared types, codes and defaults of the lut color segmenter
package lcs_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned TABLE_DEPTH_DEF = 32768;
  localparam int unsigned COLOR_COUNT_DEF = 8;
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned MAX_HEIGHT_DEF  = 1024;

  // fixed field widths
  localparam int unsigned ADDR_MAX_W = 18;  // table address room for the largest table
  localparam int unsigned DIM_W      = 13;  // frame geometry compares, up to 8191
  localparam int unsigned GEOM_W     = 11;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned INDEX_W    = 20;
  localparam int unsigned ROWNUM_W   = 11;
  localparam int unsigned CFG_IDX_W  = 3;

  // register reset values
  localparam logic [GEOM_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [GEOM_W-1:0]  FRAME_HEIGHT_RST = 11'd480;
  localparam logic [WORD_W-1:0]  RED_MASK_RST     = 32'h00F8_0000;
  localparam logic [SHIFT_W-1:0] RED_SHIFT_RST    = 5'd9;
  localparam logic [WORD_W-1:0]  GREEN_MASK_RST   = 32'h0000_F800;
  localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST  = 5'd6;
  localparam logic [WORD_W-1:0]  BLUE_MASK_RST    = 32'h0000_00F8;
  localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST   = 5'd3;

  typedef enum logic [1:0] {
    CMD_CLASSIFY = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_LIST  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RED_MASK     = 3'd2,
    REG_RED_SHIFT    = 3'd3,
    REG_GREEN_MASK   = 3'd4,
    REG_GREEN_SHIFT  = 3'd5,
    REG_BLUE_MASK    = 3'd6,
    REG_BLUE_SHIFT   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ROWCNT,
    ST_PIXEL,
    ST_LIST,
    ST_SENT
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] pixel_word;
    logic [7:0]  entry_value;
    logic [2:0]  color_number;
  } in_item_t;

  typedef struct packed {
    kind_e                 record_kind;
    logic [7:0]            class_mask;
    logic [2:0]            color_id;
    logic [COUNT_W-1:0]    list_slot;
    logic [INDEX_W-1:0]    pixel_index;
    logic [ROWNUM_W-1:0]   row_number;
    logic                  last_of_run;
  } out_item_t;

  // quantized command handed from front to back
  typedef struct packed {
    cmd_e                  command;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            entry_value;
    logic [2:0]            color_number;
  } cmd_entry_t;

  typedef struct packed {
    logic [GEOM_W-1:0] frame_width;
    logic [GEOM_W-1:0] frame_height;
  } geom_t;

endpackage

[hdl/lcs_front.sv]
// front end: config registers, pixel quantizer and command queue
module lcs_front #(
  parameter int unsigned TABLE_DEPTH = lcs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  lcs_pkg::in_item_t                    in_item_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  input  logic                                 hold_i,
  output lcs_pkg::cmd_entry_t                  head_o,
  output logic                                 head_valid_o,
  input  logic                                 head_pop_i,
  output lcs_pkg::geom_t                       geom_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned AMW    = lcs_pkg::ADDR_MAX_W;

  logic [lcs_pkg::GEOM_W-1:0]  frame_width_q, frame_height_q;
  logic [31:0]                 red_mask_q, green_mask_q, blue_mask_q;
  logic [lcs_pkg::SHIFT_W-1:0] red_shift_q, green_shift_q, blue_shift_q;

  logic [31:0]          qword;
  lcs_pkg::cmd_entry_t  entry;
  lcs_pkg::cmd_entry_t  fifo_q [2];
  logic                 wptr_q, rptr_q;
  logic [1:0]           cnt_q;
  logic                 accept;

  assign cfg_ready_o = 1'b1;

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lcs_pkg::FRAME_WIDTH_RST;
      frame_height_q <= lcs_pkg::FRAME_HEIGHT_RST;
      red_mask_q     <= lcs_pkg::RED_MASK_RST;
      red_shift_q    <= lcs_pkg::RED_SHIFT_RST;
      green_mask_q   <= lcs_pkg::GREEN_MASK_RST;
      green_shift_q  <= lcs_pkg::GREEN_SHIFT_RST;
      blue_mask_q    <= lcs_pkg::BLUE_MASK_RST;
      blue_shift_q   <= lcs_pkg::BLUE_SHIFT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lcs_pkg::cfg_reg_e'(cfg_index_i))
        lcs_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[lcs_pkg::GEOM_W-1:0];
        lcs_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[lcs_pkg::GEOM_W-1:0];
        lcs_pkg::REG_RED_MASK:     red_mask_q     <= cfg_data_i;
        lcs_pkg::REG_RED_SHIFT:    red_shift_q    <= cfg_data_i[lcs_pkg::SHIFT_W-1:0];
        lcs_pkg::REG_GREEN_MASK:   green_mask_q   <= cfg_data_i;
        lcs_pkg::REG_GREEN_SHIFT:  green_shift_q  <= cfg_data_i[lcs_pkg::SHIFT_W-1:0];
        lcs_pkg::REG_BLUE_MASK:    blue_mask_q    <= cfg_data_i;
        lcs_pkg::REG_BLUE_SHIFT:   blue_shift_q   <= cfg_data_i[lcs_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom_o.frame_width  = frame_width_q;
  assign geom_o.frame_height = frame_height_q;

  // quantize the pixel to a table address (table depth is a power of two)
  always_comb begin
    qword = ((in_item_i.pixel_word & red_mask_q)   >> red_shift_q)
          | ((in_item_i.pixel_word & green_mask_q) >> green_shift_q)
          | ((in_item_i.pixel_word & blue_mask_q)  >> blue_shift_q);
    entry.command      = in_item_i.command;
    entry.addr         = AMW'(qword[ADDR_W-1:0]);
    entry.entry_value  = in_item_i.entry_value;
    entry.color_number = in_item_i.color_number;
  end

  // two-entry command queue
  assign full         = (cnt_q == 2'd2) || hold_i;
  assign accept       = push && !full;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (accept) begin
        wptr_q <= ~wptr_q;
      end
      if (head_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, head_pop_i};
    end
  end

endmodule

[hdl/lcs_back.sv]
// back end: class table, clear sweeps, counters and record sequencer
module lcs_back #(
  parameter int unsigned TABLE_DEPTH = lcs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned COLOR_COUNT = lcs_pkg::COLOR_COUNT_DEF,
  parameter int unsigned MAX_WIDTH   = lcs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = lcs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcs_pkg::cmd_entry_t  head_i,
  input  logic                 head_valid_i,
  output logic                 head_pop_o,
  output logic                 init_busy_o,
  input  lcs_pkg::geom_t       geom_i,
  output logic                 empty,
  input  logic                 pop,
  output lcs_pkg::out_item_t   out_item_o
);

  localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CIDX_W  = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
  localparam int unsigned COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DIM_W   = lcs_pkg::DIM_W;
  localparam int unsigned CNT_W   = lcs_pkg::COUNT_W;
  localparam int unsigned IDX_W   = lcs_pkg::INDEX_W;
  localparam int unsigned RN_W    = lcs_pkg::ROWNUM_W;
  localparam logic [7:0]  VALID_MASK  = 8'((16'd1 << COLOR_COUNT) - 16'd1);
  localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(COLOR_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  lcs_pkg::state_e state_q, state_d;

  // class table
  logic [7:0]        table_mem [TABLE_DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [7:0]        mem_wd;

  // sweep control
  logic [ADDR_W-1:0] sweep_q, wr_addr_q;
  logic              rd_done_q, pend_q;
  logic [7:0]        clr_mask_q;

  // frame counters
  logic [CNT_W-1:0]  counts_q [COLOR_COUNT];
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [IDX_W-1:0]  raster_q, pidx_q;
  logic [CIDX_W-1:0] idx_q;
  logic [7:0]        rem_q;
  logic              flast_q;

  // output register
  lcs_pkg::out_item_t out_q;
  logic               out_valid_q;
  logic               out_free, fire;
  lcs_pkg::out_item_t rec;

  // derived datapath values
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              col_last, row_last, frame_last;
  logic [7:0]        rem_init, rem_next;
  logic [2:0]        bit_sel;
  logic [CIDX_W-1:0] cnt_ridx;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              head_is_cls;

  // effective geometry and end-of-row / end-of-frame detection
  always_comb begin
    if (geom_i.frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(geom_i.frame_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(geom_i.frame_width);
    end
    if (geom_i.frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(geom_i.frame_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(geom_i.frame_height);
    end
    col_last   = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
    row_last   = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;
    frame_last = col_last && row_last;
  end

  // lowest set color bit still to be listed
  always_comb begin
    bit_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem_q[i]) begin
        bit_sel = 3'(i);
      end
    end
    rem_next = rem_q & ~(8'd1 << bit_sel);
    rem_init = rdata_q & VALID_MASK;
  end

  // one read port on the count registers
  assign cnt_ridx  = (state_q == lcs_pkg::ST_LIST) ? bit_sel[CIDX_W-1:0] : idx_q;
  assign cnt_rdata = counts_q[cnt_ridx];

  assign out_free    = !out_valid_q || pop;
  assign head_is_cls = (head_i.command == lcs_pkg::CMD_CLASSIFY);
  assign init_busy_o = (state_q == lcs_pkg::ST_INIT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcs_pkg::ST_INIT: begin
        if (sweep_q == LAST_ADDR) state_d = lcs_pkg::ST_IDLE;
      end
      lcs_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.command)
            lcs_pkg::CMD_CLASSIFY:
              state_d = (col_q == '0) ? lcs_pkg::ST_ROWCNT : lcs_pkg::ST_PIXEL;
            lcs_pkg::CMD_CLEAR: state_d = lcs_pkg::ST_CLEAR;
            default:            state_d = lcs_pkg::ST_IDLE;
          endcase
        end
      end
      lcs_pkg::ST_CLEAR: begin
        if (rd_done_q && pend_q) state_d = lcs_pkg::ST_IDLE;
      end
      lcs_pkg::ST_ROWCNT: begin
        if (out_free && idx_q == LAST_IDX) state_d = lcs_pkg::ST_PIXEL;
      end
      lcs_pkg::ST_PIXEL: begin
        if (out_free) begin
          if (rem_init != '0)  state_d = lcs_pkg::ST_LIST;
          else if (frame_last) state_d = lcs_pkg::ST_SENT;
          else                 state_d = lcs_pkg::ST_IDLE;
        end
      end
      lcs_pkg::ST_LIST: begin
        if (out_free && rem_next == '0) begin
          state_d = flast_q ? lcs_pkg::ST_SENT : lcs_pkg::ST_IDLE;
        end
      end
      lcs_pkg::ST_SENT: begin
        if (out_free && idx_q == LAST_IDX) state_d = lcs_pkg::ST_IDLE;
      end
      default: state_d = lcs_pkg::ST_INIT;
    endcase
  end

  // outputs of the sequencer: memory controls, queue pop, record
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = head_i.addr[ADDR_W-1:0];
    mem_ra     = head_i.addr[ADDR_W-1:0];
    mem_wd     = head_i.entry_value;
    head_pop_o = 1'b0;
    fire       = 1'b0;
    rec        = '0;
    unique case (state_q)
      lcs_pkg::ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = sweep_q;
        mem_wd = '0;
      end
      lcs_pkg::ST_IDLE: begin
        head_pop_o = head_valid_i;
        mem_we     = head_valid_i && (head_i.command == lcs_pkg::CMD_WRITE);
        mem_re     = head_valid_i && head_is_cls;
      end
      lcs_pkg::ST_CLEAR: begin
        mem_re = !rd_done_q;
        mem_ra = sweep_q;
        mem_we = pend_q;
        mem_wa = wr_addr_q;
        mem_wd = rdata_q & clr_mask_q;
      end
      lcs_pkg::ST_ROWCNT: begin
        fire            = out_free;
        rec.record_kind = lcs_pkg::KIND_COUNT;
        rec.color_id    = 3'(idx_q);
        rec.list_slot   = cnt_rdata;
        rec.row_number  = RN_W'(row_q);
      end
      lcs_pkg::ST_PIXEL: begin
        fire            = out_free;
        rec.record_kind = lcs_pkg::KIND_PIXEL;
        rec.class_mask  = rdata_q;
        rec.pixel_index = raster_q;
        rec.last_of_run = (rem_init == '0) && !frame_last;
      end
      lcs_pkg::ST_LIST: begin
        fire            = out_free;
        rec.record_kind = lcs_pkg::KIND_LIST;
        rec.color_id    = bit_sel;
        rec.list_slot   = cnt_rdata;
        rec.pixel_index = pidx_q;
        rec.last_of_run = (rem_next == '0) && !flast_q;
      end
      lcs_pkg::ST_SENT: begin
        fire            = out_free;
        rec.record_kind = lcs_pkg::KIND_COUNT;
        rec.color_id    = 3'(idx_q);
        rec.list_slot   = cnt_rdata;
        rec.row_number  = h_eff[RN_W-1:0];
        rec.last_of_run = (idx_q == LAST_IDX);
      end
      default: ;
    endcase
  end

  // class table memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= table_mem[mem_ra];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // sweep counters for the reset fill and the color clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= '0;
      wr_addr_q  <= '0;
      rd_done_q  <= 1'b0;
      pend_q     <= 1'b0;
      clr_mask_q <= '0;
    end else begin
      unique case (state_q)
        lcs_pkg::ST_INIT: begin
          sweep_q <= sweep_q + ADDR_W'(1);
        end
        lcs_pkg::ST_IDLE: begin
          sweep_q    <= '0;
          rd_done_q  <= 1'b0;
          pend_q     <= 1'b0;
          clr_mask_q <= ~(8'd1 << head_i.color_number);
        end
        lcs_pkg::ST_CLEAR: begin
          pend_q    <= !rd_done_q;
          wr_addr_q <= sweep_q;
          if (!rd_done_q) begin
            if (sweep_q == LAST_ADDR) rd_done_q <= 1'b1;
            else                      sweep_q   <= sweep_q + ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // frame position, counts and list bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      raster_q <= '0;
      pidx_q   <= '0;
      idx_q    <= '0;
      rem_q    <= '0;
      flast_q  <= 1'b0;
      for (int i = 0; i < COLOR_COUNT; i++) counts_q[i] <= '0;
    end else begin
      if (head_pop_o && head_i.command == lcs_pkg::CMD_RESTART) begin
        col_q    <= '0;
        row_q    <= '0;
        raster_q <= '0;
        for (int i = 0; i < COLOR_COUNT; i++) counts_q[i] <= '0;
      end
      if (fire) begin
        unique case (state_q)
          lcs_pkg::ST_ROWCNT: begin
            idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + CIDX_W'(1);
          end
          lcs_pkg::ST_PIXEL: begin
            pidx_q   <= raster_q;
            raster_q <= raster_q + IDX_W'(1);
            rem_q    <= rem_init;
            flast_q  <= frame_last;
            if (col_last) begin
              col_q <= '0;
              if (!row_last) row_q <= row_q + ROW_W'(1);
            end else begin
              col_q <= col_q + COL_W'(1);
            end
          end
          lcs_pkg::ST_LIST: begin
            rem_q              <= rem_next;
            counts_q[cnt_ridx] <= cnt_rdata + CNT_W'(1);
          end
          lcs_pkg::ST_SENT: begin
            if (idx_q == LAST_IDX) begin
              idx_q    <= '0;
              row_q    <= '0;
              col_q    <= '0;
              raster_q <= '0;
              for (int i = 0; i < COLOR_COUNT; i++) counts_q[i] <= '0;
            end else begin
              idx_q <= idx_q + CIDX_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rec;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  // commands leave the queue only when the sequencer is idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> state_q == lcs_pkg::ST_IDLE)
    else $error("command queue popped outside idle");

  // a list step always has a color bit left to report
  a_list_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcs_pkg::ST_LIST |-> rem_q != '0)
    else $error("list step with no color bit left");

  // table is never written while records of a pixel are in flight
  a_we_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == lcs_pkg::ST_INIT || state_q == lcs_pkg::ST_IDLE ||
                state_q == lcs_pkg::ST_CLEAR))
    else $error("table write during record emission");

  // the last sentinel returns the frame position to the origin
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_q == lcs_pkg::ST_SENT && idx_q == LAST_IDX) |=>
      (row_q == '0 && col_q == '0 && raster_q == '0))
    else $error("frame position not cleared after sentinels");

endmodule

[hdl/lut_color_segmenter_with_run_lists.sv]
// top level of the lut color segmenter with per-color run lists
//
// After reset the class table is zero-filled over all TABLE_DEPTH entries
// (32768 by default) with full held high; configuration writes are taken
// throughout. Commands enter a two-deep queue and are carried out one at a
// time by the back-end sequencer, which has one table read port, one table
// write port and one result register. A table write or a frame restart is
// done as its command is popped in the idle state. A classify pops the queue
// and reads the table, then issues one result record per cycle while pop
// keeps up: one pixel record, one list record per set color bit, COLOR_COUNT
// row-start counts at the first pixel of a row and COLOR_COUNT sentinel
// counts after the last pixel of the frame. Clearing a color bit walks the
// whole table by read-modify-write. TABLE_DEPTH must be a power of two.
module lut_color_segmenter_with_run_lists #(
  parameter int unsigned TABLE_DEPTH = lcs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned COLOR_COUNT = lcs_pkg::COLOR_COUNT_DEF,
  parameter int unsigned MAX_WIDTH   = lcs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = lcs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  lcs_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output lcs_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  lcs_pkg::cmd_entry_t head;
  logic                head_valid, head_pop, init_busy;
  lcs_pkg::geom_t      geom;

  // input side: config registers, quantizer and command queue
  lcs_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .hold_i       (init_busy),
    .head_o       (head),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop),
    .geom_o       (geom)
  );

  // execution side
  lcs_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COLOR_COUNT(COLOR_COUNT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .init_busy_o  (init_busy),
    .geom_i       (geom),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule
